@@ src/timed_command_scheduler_core_assert.svh @@
// assertion macros for the timed command scheduler core
// expects clk_i and rst_ni in the scope of the including module
`ifndef TIMED_COMMAND_SCHEDULER_CORE_ASSERT_SVH
`define TIMED_COMMAND_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tcs_pkg.sv @@
// shared types and constants of the timed command scheduler
// no dependencies
`default_nettype none

package tcs_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned CMD_ID_W = 8;
  localparam int unsigned DELAY_W  = 16;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10000;

  // item kind
  typedef enum logic {
    MODE_POLL = 1'b0,
    MODE_ENQ  = 1'b1
  } mode_e;

  // search state handed from cell to cell
  typedef struct packed {
    mode_e             mode;
    logic              found;
    logic [TIME_W-1:0] limit;
  } probe_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic              set;
    logic              clr;
    logic [TIME_W-1:0] due;
  } upd_t;

endpackage

`default_nettype wire

@@ src/tcs_ifs.sv @@
// valid/ready channel interfaces of the timed command scheduler
// depends on tcs_pkg
`default_nettype none

// input item channel
interface tcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [tcs_pkg::TIME_W-1:0]    now_time;
  logic [tcs_pkg::CMD_ID_W-1:0]  command_id;
  logic [tcs_pkg::DELAY_W-1:0]   delay_ticks;
  logic                          first_of_batch;

  modport source (output valid, mode, now_time, command_id, delay_ticks, first_of_batch,
                  input ready);
  modport sink (input valid, mode, now_time, command_id, delay_ticks, first_of_batch,
                output ready);
endinterface

// result item channel
interface tcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          fired;
  logic [tcs_pkg::CMD_ID_W-1:0]  fired_command;
  logic                          dropped;

  modport source (output valid, fired, fired_command, dropped, input ready);
  modport sink (input valid, fired, fired_command, dropped, output ready);
endinterface

// lookahead window write channel
interface tcs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcs_pkg::WINDOW_W-1:0]   lookahead_window;

  modport source (output valid, lookahead_window, input ready);
  modport sink (input valid, lookahead_window, output ready);
endinterface

`default_nettype wire

@@ src/tcs_cell.sv @@
// one slot cell: holds pending flag, due time and command of one slot
// and passes the search probe on to the next cell; depends on tcs_pkg
`default_nettype none

module tcs_cell #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CMD_W    = 8,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // probe from the previous cell
  input  wire                 probe_vld_i,
  input  wire tcs_pkg::probe_t probe_i,
  input  wire  [IDX_W-1:0]    probe_idx_i,
  input  wire  [CMD_W-1:0]    probe_cmd_i,
  // probe to the next cell
  output logic                probe_vld_o,
  output tcs_pkg::probe_t     probe_o,
  output logic [IDX_W-1:0]    probe_idx_o,
  output logic [CMD_W-1:0]    probe_cmd_o,
  // slot update
  input  wire tcs_pkg::upd_t  upd_i,
  input  wire  [IDX_W-1:0]    upd_idx_i,
  input  wire  [CMD_W-1:0]    upd_cmd_i
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic                        pending_q;
  logic [tcs_pkg::TIME_W-1:0]  due_q;
  logic [CMD_W-1:0]            cmd_q;

  logic                        probe_vld_q;
  tcs_pkg::probe_t             probe_q, probe_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic [CMD_W-1:0]            pcmd_q, pcmd_d;

  logic                        hit;

  assign hit = (upd_idx_i == MyIdx);

  // compare this slot against the search so far
  always_comb begin
    probe_d = probe_i;
    idx_d   = probe_idx_i;
    pcmd_d  = probe_cmd_i;
    if (probe_i.mode == tcs_pkg::MODE_ENQ) begin
      // lowest free slot
      if (!probe_i.found && !pending_q) begin
        probe_d.found = 1'b1;
        idx_d         = MyIdx;
      end
    end else if (pending_q && (due_q < probe_i.limit)) begin
      // earlier pending slot, strict compare keeps the lower slot on ties
      probe_d.found = 1'b1;
      probe_d.limit = due_q;
      idx_d         = MyIdx;
      pcmd_d        = cmd_q;
    end
  end

  // probe valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_vld_q <= 1'b0;
    end else begin
      probe_vld_q <= probe_vld_i;
    end
  end

  // probe payload
  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    idx_q   <= idx_d;
    pcmd_q  <= pcmd_d;
  end

  // slot pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (hit && upd_i.set) begin
      pending_q <= 1'b1;
    end else if (hit && upd_i.clr) begin
      pending_q <= 1'b0;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (hit && upd_i.set) begin
      due_q <= upd_i.due;
      cmd_q <= upd_cmd_i;
    end
  end

  assign probe_vld_o = probe_vld_q;
  assign probe_o     = probe_q;
  assign probe_idx_o = idx_q;
  assign probe_cmd_o = pcmd_q;

endmodule

`default_nettype wire

@@ src/timed_command_scheduler_core.sv @@
// Timed command scheduler: SLOT_COUNT slots of pending commands with due
// times. Every item, enqueue or poll, sends one probe down a row of slot
// cells, one cell per clock starting at the accepting edge; the search
// outcome is latched in the cycle after the last cell and committed from
// ST_DONE once the output register is free. The result is registered at
// the commit, and the next item is taken once the sequencer is back in
// ST_IDLE. One item is in work at a time; the result sits in an output
// register while the next item is taken, and a result still waiting there
// holds back the next commit.
// Enqueue takes the lowest free slot (dropped when none is free); poll
// releases the earliest due command inside now + lookahead_window if it is
// not later than now. The lookahead_window write is taken at any time and
// resets to 10000.
// depends on tcs_pkg, tcs_ifs, tcs_cell and the assertion macro header
`default_nettype none

module timed_command_scheduler_core #(
  parameter int unsigned SLOT_COUNT   = 16,
  parameter int unsigned COMMAND_BITS = 8
) (
  input wire            clk_i,
  input wire            rst_ni,
  tcs_in_if.sink        in_i,
  tcs_out_if.source     out_o,
  tcs_cfg_if.sink       cfg_i
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CMD_W = COMMAND_BITS;
  localparam int unsigned TW    = tcs_pkg::TIME_W;
  localparam int unsigned IW    = tcs_pkg::CMD_ID_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [tcs_pkg::WINDOW_W-1:0] window_q;
  logic [TW-1:0]                running_q, running_d;

  // registered item
  tcs_pkg::mode_e               mode_q;
  logic [TW-1:0]                now_q;
  logic [CMD_W-1:0]             cmd_q;
  logic [tcs_pkg::DELAY_W-1:0]  delay_q;
  logic                         first_q;

  // scan result
  tcs_pkg::probe_t              res_q;
  logic [IDX_W-1:0]             res_idx_q;
  logic [CMD_W-1:0]             res_cmd_q;

  // output register
  logic                         out_valid_q;
  logic                         fired_q, fired_d;
  logic [IW-1:0]                fcmd_q, fcmd_d;
  logic                         dropped_q, dropped_d;

  // cell chain
  logic                         chain_vld [SLOT_COUNT+1];
  tcs_pkg::probe_t              chain_probe [SLOT_COUNT+1];
  logic [IDX_W-1:0]             chain_idx [SLOT_COUNT+1];
  logic [CMD_W-1:0]             chain_cmd [SLOT_COUNT+1];

  tcs_pkg::upd_t                upd;
  logic                         accept;
  logic                         commit;
  logic [TW-1:0]                base;
  logic [TW-1:0]                due_sum;
  logic [CMD_W+IW-1:0]          cmd_in_ext;
  logic [IW+CMD_W-1:0]          cmd_out_ext;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign commit      = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // command id resized to the slot command width
  assign cmd_in_ext  = {{CMD_W{1'b0}}, in_i.command_id};
  assign cmd_out_ext = {{IW{1'b0}}, res_cmd_q};

  // probe injection into the first cell
  assign chain_vld[0]         = accept;
  assign chain_probe[0].mode  = tcs_pkg::mode_e'(in_i.mode);
  assign chain_probe[0].found = 1'b0;
  assign chain_probe[0].limit = TW'(in_i.now_time + TW'(window_q));
  assign chain_idx[0]         = '0;
  assign chain_cmd[0]         = '0;

  // row of slot cells
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    tcs_cell #(
      .IDX_W    (IDX_W),
      .CMD_W    (CMD_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .probe_vld_i (chain_vld[g]),
      .probe_i     (chain_probe[g]),
      .probe_idx_i (chain_idx[g]),
      .probe_cmd_i (chain_cmd[g]),
      .probe_vld_o (chain_vld[g+1]),
      .probe_o     (chain_probe[g+1]),
      .probe_idx_o (chain_idx[g+1]),
      .probe_cmd_o (chain_cmd[g+1]),
      .upd_i       (upd),
      .upd_idx_i   (res_idx_q),
      .upd_cmd_i   (cmd_q)
    );
  end

  // commit: slot update, running due time and result
  assign base    = first_q ? now_q : running_q;
  assign due_sum = TW'(base + TW'(delay_q));

  always_comb begin
    upd.set   = 1'b0;
    upd.clr   = 1'b0;
    upd.due   = due_sum;
    running_d = running_q;
    fired_d   = 1'b0;
    fcmd_d    = '0;
    dropped_d = 1'b0;
    if (commit) begin
      if (mode_q == tcs_pkg::MODE_ENQ) begin
        if (res_q.found) begin
          upd.set   = 1'b1;
          running_d = due_sum;
        end else begin
          dropped_d = 1'b1;
          running_d = base;
        end
      end else if (res_q.found && (res_q.limit <= now_q)) begin
        upd.clr = 1'b1;
        fired_d = 1'b1;
        fcmd_d  = cmd_out_ext[IW-1:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (chain_vld[SLOT_COUNT]) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= tcs_pkg::WINDOW_RESET;
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      if (cfg_i.valid) begin
        window_q <= cfg_i.lookahead_window;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item, scan result and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= tcs_pkg::mode_e'(in_i.mode);
      now_q   <= in_i.now_time;
      cmd_q   <= cmd_in_ext[CMD_W-1:0];
      delay_q <= in_i.delay_ticks;
      first_q <= in_i.first_of_batch;
    end
    if ((state_q == ST_SCAN) && chain_vld[SLOT_COUNT]) begin
      res_q     <= chain_probe[SLOT_COUNT];
      res_idx_q <= chain_idx[SLOT_COUNT];
      res_cmd_q <= chain_cmd[SLOT_COUNT];
    end
    if (commit) begin
      fired_q   <= fired_d;
      fcmd_q    <= fcmd_d;
      dropped_q <= dropped_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fired         = fired_q;
  assign out_o.fired_command = fcmd_q;
  assign out_o.dropped       = dropped_q;

  // checks
  `include "timed_command_scheduler_core_assert.svh"

  `TCS_ASSERT_IMP(a_probe_exit_in_scan, chain_vld[SLOT_COUNT], state_q == ST_SCAN, "probe left chain outside scan")
  `TCS_ASSERT_NXT(a_accept_starts_scan, accept, state_q == ST_SCAN, "accepted item did not start scan")
  `TCS_ASSERT_NXT(a_commit_loads_out, commit, out_valid_q, "commit did not load result")
  `TCS_ASSERT_IMP(a_fire_drop_excl, out_valid_q, !(fired_q && dropped_q), "fired and dropped together")

endmodule

`default_nettype wire
